// ----- rtl/smp_pkg.sv -----
package smp_pkg;

	// padding sequencer states
	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_MARK,
		SEQ_ZERO,
		SEQ_LEN
	} seq_state_t;

	// one byte handed from the sequencer to the byte packer
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} byte_put_t;

	localparam int unsigned COUNT_W = 61;
	localparam int unsigned LEN_W   = 64;
	localparam int unsigned POS_W   = 6;

	localparam logic [7:0]       PAD_MARK = 8'h80;
	localparam logic [POS_W-1:0] LEN_POS  = 6'd56;

endpackage

// ----- rtl/smp_byte_packer.sv -----
module smp_byte_packer (
	input  logic               clk,
	input  logic               arst_n,
	input  smp_pkg::byte_put_t put,
	output logic               ready,
	output logic [5:0]         pos,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [39:0]        m_tdata,  // word[31:0], word_index[35:32], zero fill
	output logic               m_tuser,  // block_end
	output logic               m_tlast   // message_end
);

	logic [23:0] acc_q;
	logic [5:0]  pos_q;
	logic        valid_q;
	logic [31:0] word_q;
	logic [3:0]  idx_q;
	logic        blk_q;
	logic        last_q;
	logic        fire;
	logic        word_done;

	// a byte is taken whenever the output register is free or draining
	assign ready     = !valid_q || m_tready;
	assign fire      = put.valid && ready;
	assign word_done = (pos_q[1:0] == 2'd3);
	assign pos       = pos_q;

	// byte position and partial word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pos_q <= '0;
		end else if (fire) begin
			pos_q <= pos_q + 6'd1;
			if (word_done) begin
				acc_q <= '0;
			end else begin
				acc_q <= {acc_q[15:0], put.data};
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire && word_done) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (fire && word_done) begin
			word_q <= {acc_q, put.data};
			idx_q  <= pos_q[5:2];
			blk_q  <= &pos_q;
			last_q <= put.last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {4'd0, idx_q, word_q};
	assign m_tuser  = blk_q;
	assign m_tlast  = last_q;

endmodule

// ----- rtl/smp_pad_seq.sv -----
module smp_pad_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,  // msg_byte
	input  logic               s_tuser,  // kind
	input  logic               byte_ready,
	input  logic [5:0]         pos,
	output smp_pkg::byte_put_t put
);

	smp_pkg::seq_state_t state_q, state_d;

	logic [smp_pkg::COUNT_W-1:0] count_q;
	logic [smp_pkg::LEN_W-1:0]   len_q;
	logic [2:0]                  len_cnt_q;
	logic                        s_fire;

	assign s_fire = s_tvalid && s_tready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smp_pkg::SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and byte selection
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		put.valid  = 1'b0;
		put.data   = 8'd0;
		put.last   = 1'b0;
		unique case (state_q)
			smp_pkg::SEQ_IDLE: begin
				s_tready  = byte_ready;
				put.valid = s_tvalid && !s_tuser;
				put.data  = s_tdata;
				if (s_fire && s_tuser) begin
					state_d = smp_pkg::SEQ_MARK;
				end
			end
			smp_pkg::SEQ_MARK: begin
				put.valid = 1'b1;
				put.data  = smp_pkg::PAD_MARK;
				if (byte_ready) begin
					state_d = smp_pkg::SEQ_ZERO;
				end
			end
			smp_pkg::SEQ_ZERO: begin
				put.valid = (pos != smp_pkg::LEN_POS);
				if (pos == smp_pkg::LEN_POS) begin
					state_d = smp_pkg::SEQ_LEN;
				end
			end
			smp_pkg::SEQ_LEN: begin
				put.valid = 1'b1;
				put.data  = len_q[smp_pkg::LEN_W-1 -: 8];
				put.last  = &len_cnt_q;
				if (byte_ready && (&len_cnt_q)) begin
					state_d = smp_pkg::SEQ_IDLE;
				end
			end
			default: begin
				state_d = smp_pkg::SEQ_IDLE;
			end
		endcase
	end

	// message byte count, bit length shifter and length byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			len_q     <= '0;
			len_cnt_q <= '0;
		end else begin
			if (s_fire) begin
				if (s_tuser) begin
					len_q     <= {count_q, 3'b000};
					len_cnt_q <= '0;
					count_q   <= '0;
				end else begin
					count_q <= count_q + {{(smp_pkg::COUNT_W-1){1'b0}}, 1'b1};
				end
			end
			if (state_q == smp_pkg::SEQ_LEN && byte_ready) begin
				len_q     <= {len_q[smp_pkg::LEN_W-9:0], 8'd0};
				len_cnt_q <= len_cnt_q + 3'd1;
			end
		end
	end

endmodule

// ----- rtl/sha256_message_padder.sv -----
// output: a byte that completes a word shows that word in the cycle after its transfer
// throughput: one message byte per cycle while the output side keeps up
// end marker: taken while idle, then the 0x80 mark byte, a zero fill of 0 to 63 bytes,
// a turn step once the fill reaches byte 56 and 8 length bytes, all through the single
// byte packer; no input is taken until the last length byte has gone in
// reset: arst_n clears byte count, partial word, block position and state at once
module sha256_message_padder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // msg_byte[7:0]
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // word[31:0], word_index[35:32], zero fill[39:36]
	output logic        m_tuser,  // block_end
	output logic        m_tlast   // message_end
);

	smp_pkg::byte_put_t put;
	logic               byte_ready;
	logic [5:0]         pos;

	// padding sequencer
	smp_pad_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.byte_ready (byte_ready),
		.pos        (pos),
		.put        (put)
	);

	// shared byte packer with output register
	smp_byte_packer u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.put      (put),
		.ready    (byte_ready),
		.pos      (pos),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- rtl/smp_checker.sv -----
module smp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// block end only on the last word of a block
	a_blk: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[35:32] == 4'hf)
		else $error("block end on wrong word index");

	// message end always closes a block
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("message end without block end");

	// no input while padding starts after an end marker
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !s_tready)
		else $error("input taken right after end marker");

endmodule

bind sha256_message_padder smp_checker u_smp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ----- tb/tb_sha256_message_padder.sv -----
module tb_sha256_message_padder;

	// input item kinds carried on tuser
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [smp_pkg::POS_W-1:0] BLOCK_LAST = 6'd63;
	localparam int LEN_BYTES   = smp_pkg::LEN_W / 8;
	localparam int ITEM_TARGET = 430;
	localparam int LONG_HOLD   = 300;
	localparam int TAIL_CYCLES = 40;
	localparam int TIMEOUT     = 2000000;

	typedef enum int {RX_OPEN, RX_PATTERN, RX_RANDOM} rx_mode_t;

	// one expected output word
	typedef struct packed {
		logic [31:0] word;
		logic [3:0]  idx;
		logic        blk_end;
		logic        msg_end;
	} pad_word_t;

	// predicts the padded word stream and checks it in order
	class sha_pad_model;
		logic [smp_pkg::COUNT_W-1:0] byte_count;
		logic [31:0]                 acc;
		logic [smp_pkg::POS_W-1:0]   pos;
		pad_word_t                   words_due[$];
		int                          err_count;

		function new();
			err_count = 0;
			clear();
		endfunction

		function void clear();
			byte_count = '0;
			acc        = '0;
			pos        = '0;
		endfunction

		// shift a byte in; a full word becomes an expected output
		function void push_byte(logic [7:0] b);
			pad_word_t w;
			acc = {acc[23:0], b};
			if (pos[1:0] == 2'd3) begin
				w.word    = acc;
				w.idx     = pos[5:2];
				w.blk_end = (pos == BLOCK_LAST);
				w.msg_end = 1'b0;
				words_due.push_back(w);
				acc = '0;
			end
			pos = pos + 6'd1;
		endfunction

		// called for every accepted input transfer
		function void accept_item(logic kind, logic [7:0] b);
			logic [smp_pkg::LEN_W-1:0] bit_len;
			int i;
			if (kind == KIND_BYTE) begin
				push_byte(b);
				byte_count = byte_count + {{(smp_pkg::COUNT_W-1){1'b0}}, 1'b1};
			end else begin
				bit_len = {byte_count, 3'b000};
				push_byte(smp_pkg::PAD_MARK);
				while (pos != smp_pkg::LEN_POS)
					push_byte(8'h00);
				for (i = LEN_BYTES - 1; i >= 0; i--)
					push_byte(bit_len[8*i +: 8]);
				words_due[words_due.size() - 1].msg_end = 1'b1;
				clear();
			end
		endfunction

		function void cmp_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				err_count++;
			end
		endfunction

		// called for every accepted output transfer
		function void check_word(logic [39:0] data, logic blk_end, logic msg_end);
			pad_word_t want;
			if (words_due.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time, data);
				err_count++;
				return;
			end
			want = words_due.pop_front();
			cmp_field("word", data[31:0], want.word);
			cmp_field("word_index", data[35:32], want.idx);
			cmp_field("zero fill", data[39:36], '0);
			cmp_field("block_end", blk_end, want.blk_end);
			cmp_field("message_end", msg_end, want.msg_end);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	logic hold_req  = 1'b0;
	logic hold_done = 1'b0;

	sha_pad_model pad_board;
	int burst_left;
	int items_sent;

	sha256_message_padder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#TIMEOUT;
		$display("** sha256_message_padder: FAILED **");
		$finish;
	end

	// offer one item, with a random gap between bursts
	task automatic offer(input logic kind, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		pad_board.accept_item(kind, b);
		items_sent++;
	endtask

	// hold the sender until every expected word has arrived
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pad_board.words_due.size() != 0);
	endtask

	// one message of random bytes and its end marker
	task automatic send_message(input int len);
		int i;
		for (i = 0; i < len; i++)
			offer(KIND_BYTE, 8'($urandom_range(0, 255)));
		offer(KIND_END, 8'($urandom_range(0, 255)));
	endtask

	// receiver ready pattern, with one long hold-off on request
	initial begin
		rx_mode_t   mode;
		int         run;
		logic [7:0] pat;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end
			mode = rx_mode_t'($urandom_range(0, 2));
			run  = $urandom_range(8, 60);
			pat  = 8'($urandom);
			repeat (run) begin
				case (mode)
				RX_OPEN: begin
					m_tready <= 1'b1;
				end
				RX_PATTERN: begin
					m_tready <= pat[0];
					pat = {pat[0], pat[7:1]};
				end
				default: begin
					m_tready <= ($urandom_range(0, 3) != 0);
				end
				endcase
				@(posedge clk);
			end
		end
	end

	// output transfers
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			pad_board.check_word(m_tdata, m_tuser, m_tlast);
	end

	// stimulus
	initial begin
		int len;
		int sel;
		pad_board  = new();
		burst_left = 0;
		items_sent = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tuser  = KIND_BYTE;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, marker byte set to all ones and ignored
		offer(KIND_END, 8'hFF);
		// short text message
		offer(KIND_BYTE, 8'h61);
		offer(KIND_BYTE, 8'h62);
		offer(KIND_BYTE, 8'h63);
		offer(KIND_END, 8'h00);
		drain();
		// byte extremes forming one full word
		offer(KIND_BYTE, 8'h00);
		offer(KIND_BYTE, 8'hFF);
		offer(KIND_BYTE, 8'h5A);
		offer(KIND_BYTE, 8'hA5);
		offer(KIND_END, 8'h5A);
		// all ones word, then back-to-back empty message
		offer(KIND_BYTE, 8'hFF);
		offer(KIND_BYTE, 8'hFF);
		offer(KIND_BYTE, 8'hFF);
		offer(KIND_BYTE, 8'hFF);
		offer(KIND_END, 8'hFF);
		offer(KIND_END, 8'h00);
		drain();

		// random messages, weighted toward the one/two block boundary
		while (items_sent < ITEM_TARGET) begin
			if (items_sent > 150)
				hold_req <= 1'b1;
			sel = $urandom_range(0, 9);
			if (sel < 4)
				len = $urandom_range(50, 66);
			else if (sel < 7)
				len = $urandom_range(0, 12);
			else
				len = $urandom_range(13, 140);
			send_message(len);
			if ($urandom_range(0, 7) == 0)
				drain();
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pad_board.err_count == 0 && pad_board.words_due.size() == 0)
			$display("** sha256_message_padder: PASSED **");
		else
			$display("** sha256_message_padder: FAILED **");
		$finish;
	end

endmodule
